### rtl/bcg_pkg.sv
`timescale 1ns / 1ps

package bcg_pkg;

    localparam int SAMPLES       = 128;
    localparam int PRESSURE_BITS = 20;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_ACCEPT = 2'd1;
    localparam logic [1:0] EV_REJECT = 2'd2;
    localparam logic [1:0] EV_TRACK  = 2'd3;

    localparam logic [15:0] GATE_RESET = 16'd130;
    localparam int OUT_W = 21;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 21'sd1048575;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_SORT_RD = 9'b000000010,
        ST_SORT_CP = 9'b000000100,
        ST_SORT_WR = 9'b000001000,
        ST_QRD     = 9'b000010000,
        ST_QCAP    = 9'b000100000,
        ST_CHECK   = 9'b001000000,
        ST_OUT     = 9'b010000000,
        ST_SORT_WT = 9'b100000000
    } state_t;

endpackage

### rtl/baro_calibrate_and_gate_top.sv
`timescale 1ns / 1ps
// Barometer offset calibration with an outlier check and slew-limited output.
// The input channel carries words of op and pressure under in_valid/in_stall;
// an arm word (op = 1) yields no output, a pressure word yields one output
// word of static_pressure, calibrated and cal_event under out_valid/out_stall.
// gate_width is written through cfg_we/cfg_data; the user must write it only
// while the block is idle; the block does not enforce this. An ordinary sample
// passes through ST_OUT to the output register. The first pressure word after
// the sample memory is full sorts it in place with an insertion sort over its
// single read and write port (read and compare per compare-and-move, wait and
// write-back per entry), then reads the four quartile entries and the extremes
// before answering. One word is in flight at a time; a new word is taken once
// the previous result has moved into the output register, which waits while
// out_stall holds that register. The output word holds its value while stalled.
// Reset clears the count, sum, mean, last output, armed and calibrated
// flags and sets gate_width to 130; the sample memory is not cleared.
module baro_calibrate_and_gate_top
    import bcg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     op,
    input  logic [19:0]              pressure,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [20:0]       static_pressure,
    output logic                     calibrated,
    output logic [1:0]               cal_event,
    input  logic                     cfg_we,
    input  logic [15:0]              cfg_data
);

    localparam int AW = $clog2(SAMPLES);
    localparam int CW = AW + 1;
    localparam int SW = PRESSURE_BITS + AW;
    localparam int QW = PRESSURE_BITS + 4;

    logic [PRESSURE_BITS-1:0] mem [SAMPLES];
    logic [PRESSURE_BITS-1:0] rdata_reg;
    logic [AW-1:0]            raddr;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic [PRESSURE_BITS-1:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg;
    logic [SW-1:0]            sum_reg;
    logic [PRESSURE_BITS-1:0] mean_reg;
    logic signed [OUT_W-1:0]  last_reg;
    logic                     armed_reg, done_reg;
    logic [15:0]              gate_reg;
    logic [AW-1:0]            i_reg, j_reg;
    logic [PRESSURE_BITS-1:0] key_reg;
    logic [2:0]               q_reg;
    logic [PRESSURE_BITS-1:0] qv_reg [6];
    logic                     ov_reg;
    logic signed [OUT_W-1:0]  od_reg;
    logic                     oc_reg;
    logic [1:0]               oe_reg;
    logic signed [OUT_W-1:0]  res_reg;
    logic [1:0]               ev_reg;
    logic [PRESSURE_BITS-1:0] p_reg;

    localparam logic [AW-1:0] QA0 = AW'(SAMPLES / 4 - 1);
    localparam logic [AW-1:0] QA1 = AW'(SAMPLES / 4);
    localparam logic [AW-1:0] QA2 = AW'(3 * SAMPLES / 4 - 1);
    localparam logic [AW-1:0] QA3 = AW'(3 * SAMPLES / 4);
    localparam logic [AW-1:0] QA5 = AW'(SAMPLES - 1);

    function automatic logic [AW-1:0] qaddr(input logic [2:0] q);
        unique case (q)
            3'd0:    qaddr = QA0;
            3'd1:    qaddr = QA1;
            3'd2:    qaddr = QA2;
            3'd3:    qaddr = QA3;
            3'd4:    qaddr = '0;
            default: qaddr = QA5;
        endcase
    endfunction

    logic accept;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_valid       = ov_reg;
    assign static_pressure = od_reg;
    assign calibrated      = oc_reg;
    assign cal_event       = oe_reg;

    logic signed [QW-1:0] q1x2, q3x2, iqr, hi, lo, smin, smax;
    assign q1x2 = QW'(qv_reg[0]) + QW'(qv_reg[1]);
    assign q3x2 = QW'(qv_reg[2]) + QW'(qv_reg[3]);
    assign iqr  = q3x2 - q1x2;
    assign hi   = q3x2 + (iqr <<< 1);
    assign lo   = q1x2 - (iqr <<< 1);
    assign smin = QW'(qv_reg[4]) <<< 1;
    assign smax = QW'(qv_reg[5]) <<< 1;

    logic signed [OUT_W+1:0] tgt, lim_lo, lim_hi, clip;
    assign tgt    = (OUT_W+2)'(mean_reg) - (OUT_W+2)'(p_reg);
    assign lim_lo = (OUT_W+2)'(last_reg) - (OUT_W+2)'(gate_reg);
    assign lim_hi = (OUT_W+2)'(last_reg) + (OUT_W+2)'(gate_reg);

    always_comb
    begin
        if (tgt < lim_lo)
        begin
            clip = lim_lo;
        end
        else if (tgt > lim_hi)
        begin
            clip = lim_hi;
        end
        else
        begin
            clip = tgt;
        end
        if (clip > (OUT_W+2)'(OUT_MAX))
        begin
            clip = (OUT_W+2)'(OUT_MAX);
        end
        else if (clip < -(OUT_W+2)'(OUT_MAX))
        begin
            clip = -(OUT_W+2)'(OUT_MAX);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        raddr = j_reg;
        we    = 1'b0;
        waddr = j_reg;
        wdata = key_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                raddr = i_reg;
                if (accept && !op)
                begin
                    if (armed_reg && !done_reg && count_reg < CW'(SAMPLES))
                    begin
                        we    = 1'b1;
                        waddr = count_reg[AW-1:0];
                        wdata = pressure[PRESSURE_BITS-1:0];
                        state_next = ST_OUT;
                    end
                    else if (armed_reg && !done_reg)
                    begin
                        state_next = ST_SORT_WT;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SORT_WT: state_next = ST_SORT_RD;
            ST_SORT_RD:
            begin
                raddr = j_reg - AW'(1);
                state_next = ST_SORT_CP;
            end
            ST_SORT_CP:
            begin
                if (j_reg != '0 && rdata_reg > key_reg)
                begin
                    we    = 1'b1;
                    wdata = rdata_reg;
                    state_next = (j_reg == AW'(1)) ? ST_SORT_WR : ST_SORT_RD;
                end
                else
                begin
                    state_next = ST_SORT_WR;
                end
                raddr = j_reg - AW'(2);
            end
            ST_SORT_WR:
            begin
                we    = 1'b1;
                raddr = i_reg + AW'(1);
                state_next = (i_reg == AW'(SAMPLES - 1)) ? ST_QRD : ST_SORT_WT;
            end
            ST_QRD:
            begin
                raddr = qaddr(q_reg);
                state_next = ST_QCAP;
            end
            ST_QCAP:
            begin
                raddr = qaddr(q_reg);
                state_next = (q_reg == 3'd5) ? ST_CHECK : ST_QRD;
            end
            ST_CHECK:   state_next = ST_OUT;
            ST_OUT:     state_next = (ov_reg && out_stall) ? ST_OUT : ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
            mean_reg  <= '0;
            last_reg  <= '0;
            armed_reg <= 1'b0;
            done_reg  <= 1'b0;
            gate_reg  <= GATE_RESET;
            ov_reg    <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            q_reg     <= '0;
            ev_reg    <= EV_NONE;
            key_reg   <= '0;
            qv_reg    <= '{default: '0};
            od_reg    <= '0;
            oc_reg    <= 1'b0;
            oe_reg    <= EV_NONE;
            res_reg   <= '0;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                gate_reg <= cfg_data;
            end
            if (ov_reg && !out_stall && state_reg != ST_OUT)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && op)
                    begin
                        armed_reg <= 1'b1;
                    end
                    else if (accept)
                    begin
                        p_reg <= pressure[PRESSURE_BITS-1:0];
                        if (armed_reg && !done_reg && count_reg < CW'(SAMPLES))
                        begin
                            sum_reg   <= sum_reg + SW'(pressure[PRESSURE_BITS-1:0]);
                            count_reg <= count_reg + CW'(1);
                            last_reg  <= '0;
                            ev_reg    <= EV_NONE;
                            res_reg   <= '0;
                        end
                        else if (armed_reg && !done_reg)
                        begin
                            i_reg <= AW'(1);
                            j_reg <= AW'(1);
                            q_reg <= '0;
                        end
                        else
                        begin
                            ev_reg <= EV_TRACK;
                        end
                    end
                end
                ST_SORT_RD:
                begin
                    if (j_reg == i_reg)
                    begin
                        key_reg <= rdata_reg;
                    end
                end
                ST_SORT_CP:
                begin
                    if (j_reg != '0 && rdata_reg > key_reg)
                    begin
                        j_reg <= j_reg - AW'(1);
                    end
                end
                ST_SORT_WR:
                begin
                    i_reg <= i_reg + AW'(1);
                    j_reg <= i_reg + AW'(1);
                end
                ST_QCAP:
                begin
                    qv_reg[q_reg] <= rdata_reg;
                    q_reg <= q_reg + 3'd1;
                end
                ST_CHECK:
                begin
                    res_reg <= last_reg;
                    if (smax > hi || smin < lo)
                    begin
                        count_reg <= '0;
                        sum_reg   <= '0;
                        ev_reg    <= EV_REJECT;
                    end
                    else
                    begin
                        mean_reg <= sum_reg[SW-1:AW];
                        done_reg <= 1'b1;
                        ev_reg   <= EV_ACCEPT;
                    end
                end
                ST_OUT:
                begin
                    if (!(ov_reg && out_stall))
                    begin
                        ov_reg <= 1'b1;
                        if (ev_reg == EV_TRACK)
                        begin
                            last_reg <= clip[OUT_W-1:0];
                            od_reg   <= clip[OUT_W-1:0];
                            oe_reg   <= EV_NONE;
                        end
                        else
                        begin
                            od_reg <= res_reg;
                            oe_reg <= ev_reg;
                        end
                        oc_reg <= done_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
